FILE: hdl/assert_macros.svh
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define OPFC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define OPFC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/opfc_pkg.sv
package opfc_pkg;

  // CORDIC and datapath widths
  localparam int CORDIC_ITERATIONS = 16;
  localparam int SQRT_STAGES       = 32;
  localparam int CW                = 38;  // CORDIC vector and position lanes
  localparam int ZW                = 28;  // Q.24 angle accumulator
  localparam int EW                = 30;  // wrapped yaw difference
  localparam int RW                = 36;  // robot-frame position error
  localparam int HW                = 20;  // Q3.13 yaw error, full range
  localparam int PW                = 56;  // command product and rounding
  localparam int MW                = CW + 32;
  localparam int HE_SHIFT          = 11;
  localparam int LIN_SHIFT         = 8;
  localparam int TURN_SHIFT        = 5;

  localparam int ANG_PI     = 52707179;
  localparam int ANG_TWO_PI = 105414358;
  localparam logic signed [30:0] CORDIC_K = 31'sd652032874;  // Q1.30

  localparam logic [19:0] POS_DEADBAND_MIN = 20'd66;
  localparam logic [14:0] YAW_DEADBAND_MIN = 15'd8;

  localparam logic [23:0] ATAN_TABLE [25] = '{
    24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331, 24'd1047214,
    24'd524117, 24'd262123, 24'd131069, 24'd65536, 24'd32768, 24'd16384,
    24'd8192, 24'd4096, 24'd2048, 24'd1024, 24'd512, 24'd256, 24'd128,
    24'd64, 24'd32, 24'd16, 24'd8, 24'd4, 24'd2, 24'd1
  };

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QA          = $clog2(QUEUE_DEPTH);

  // Register map
  localparam logic [7:0] REG_POSITION_TOLERANCE = 8'd0;
  localparam logic [7:0] REG_HEADING_TOLERANCE  = 8'd1;
  localparam logic [7:0] REG_LINEAR_GAIN        = 8'd2;
  localparam logic [7:0] REG_LINEAR_MIN_COMMAND = 8'd3;
  localparam logic [7:0] REG_LINEAR_MAX_COMMAND = 8'd4;
  localparam logic [7:0] REG_TURN_GAIN          = 8'd5;
  localparam logic [7:0] REG_TURN_MIN_COMMAND   = 8'd6;
  localparam logic [7:0] REG_TURN_MAX_COMMAND   = 8'd7;

  typedef struct packed {
    logic [19:0] position_tolerance;
    logic [14:0] heading_tolerance;
    logic [15:0] linear_gain;
    logic [19:0] linear_min_command;
    logic [19:0] linear_max_command;
    logic [15:0] turn_gain;
    logic [19:0] turn_min_command;
    logic [19:0] turn_max_command;
  } cfg_t;

  // Classified item: saturated position error and quaternion products
  typedef struct packed {
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] n_wz;
    logic signed [31:0] n_xy;
    logic signed [31:0] n_yy;
    logic signed [31:0] n_zz;
    logic signed [31:0] g_wz;
    logic signed [31:0] g_xy;
    logic signed [31:0] g_yy;
    logic signed [31:0] g_zz;
  } front_t;

  // Minimum magnitude, symmetric clamp and deadband on a rounded command
  function automatic logic signed [20:0] finish_cmd(
    input logic signed [PW-1:0] c,
    input logic                 neg,
    input logic                 dead,
    input logic [19:0]          mn,
    input logic [19:0]          mx
  );
    logic signed [PW-1:0] r;
    logic signed [PW-1:0] ac;
    logic signed [PW-1:0] mns;
    logic signed [PW-1:0] mxs;
    ac  = (c < 0) ? -c : c;
    mns = $signed({{(PW-20){1'b0}}, mn});
    mxs = $signed({{(PW-20){1'b0}}, mx});
    r   = c;
    if (ac < mns) r = neg ? -mns : mns;
    if (r > mxs) r = mxs;
    else if (r < -mxs) r = -mxs;
    if (dead) r = '0;
    return r[20:0];
  endfunction

endpackage

FILE: hdl/opfc_front.sv
module opfc_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [255:0]     in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output opfc_pkg::front_t out_item
);
  import opfc_pkg::*;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    if (v > 33'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -33'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  logic signed [31:0] npx, npy, tpx, tpy;
  logic signed [15:0] nqx, nqy, nqz, nqw, tqx, tqy, tqz, tqw;
  front_t             item_next;
  logic               fv;

  // Field unpacking
  assign npx = in_data[31:0];
  assign npy = in_data[63:32];
  assign nqx = in_data[79:64];
  assign nqy = in_data[95:80];
  assign nqz = in_data[111:96];
  assign nqw = in_data[127:112];
  assign tpx = in_data[159:128];
  assign tpy = in_data[191:160];
  assign tqx = in_data[207:192];
  assign tqy = in_data[223:208];
  assign tqz = in_data[239:224];
  assign tqw = in_data[255:240];

  // Position error and quaternion products
  always_comb begin
    item_next.dx   = sat32(33'(tpx) - 33'(npx));
    item_next.dy   = sat32(33'(tpy) - 33'(npy));
    item_next.n_wz = 32'(nqw) * 32'(nqz);
    item_next.n_xy = 32'(nqx) * 32'(nqy);
    item_next.n_yy = 32'(nqy) * 32'(nqy);
    item_next.n_zz = 32'(nqz) * 32'(nqz);
    item_next.g_wz = 32'(tqw) * 32'(tqz);
    item_next.g_xy = 32'(tqx) * 32'(tqy);
    item_next.g_yy = 32'(tqy) * 32'(tqy);
    item_next.g_zz = 32'(tqz) * 32'(tqz);
  end

  assign in_ready  = !fv || out_ready;
  assign out_valid = fv;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (in_valid && in_ready) begin
      fv <= 1'b1;
    end else if (out_ready) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_item <= item_next;
    end
  end

endmodule

FILE: hdl/opfc_queue.sv
module opfc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  opfc_pkg::front_t in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output opfc_pkg::front_t out_item
);
  import opfc_pkg::*;

  front_t        mem [QUEUE_DEPTH];
  logic [QA-1:0] wr_ptr, rd_ptr;
  logic [QA:0]   count;
  logic          push, pop;

  assign in_ready  = (count != (QA+1)'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_item  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

endmodule

FILE: hdl/opfc_back.sv
module opfc_back (
  input  logic             clk,
  input  logic             rst,
  input  opfc_pkg::cfg_t   cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  opfc_pkg::front_t in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [111:0]     out_data
);
  import opfc_pkg::*;

  typedef struct packed {
    logic signed [CW-1:0] nvx;
    logic signed [CW-1:0] nvy;
    logic signed [CW-1:0] gvx;
    logic signed [CW-1:0] gvy;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [ZW-1:0] nz;
    logic signed [ZW-1:0] gz;
    logic                 ndeg;
    logic                 gdeg;
    logic signed [31:0]   dx;
    logic signed [31:0]   dy;
    logic [65:0]          rem;
    logic [31:0]          root;
  } stage_t;

  logic en;

  // Whole pipeline advances together; the output register frees it
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage P0: operand sums and squares
  logic                 p0v;
  logic signed [CW-1:0] p0_nvx, p0_nvy, p0_gvx, p0_gvy;
  logic signed [31:0]   p0_dx, p0_dy;
  logic signed [63:0]   p0_sqx, p0_sqy;

  always_ff @(posedge clk) begin
    if (rst) p0v <= 1'b0;
    else if (en) p0v <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_nvy <= (CW'(in_item.n_wz) + CW'(in_item.n_xy)) <<< 1;
      p0_nvx <= CW'(268435456) - ((CW'(in_item.n_yy) + CW'(in_item.n_zz)) <<< 1);
      p0_gvy <= (CW'(in_item.g_wz) + CW'(in_item.g_xy)) <<< 1;
      p0_gvx <= CW'(268435456) - ((CW'(in_item.g_yy) + CW'(in_item.g_zz)) <<< 1);
      p0_dx  <= in_item.dx;
      p0_dy  <= in_item.dy;
      p0_sqx <= 64'(in_item.dx) * 64'(in_item.dy - in_item.dy + in_item.dx);
      p0_sqy <= 64'(in_item.dy) * 64'(in_item.dy);
    end
  end

  // Stage P1: CORDIC setup into the right half plane, radicand sum
  stage_t lp [0:SQRT_STAGES];
  logic [SQRT_STAGES:0] lv;
  stage_t init;

  always_comb begin
    init.ndeg = (p0_nvx == '0) && (p0_nvy == '0);
    init.gdeg = (p0_gvx == '0) && (p0_gvy == '0);
    init.dx   = p0_dx;
    init.dy   = p0_dy;
    init.rem  = {2'b00, 64'(p0_sqx) + 64'(p0_sqy)};
    init.root = '0;
    if (p0_nvx < 0) begin
      init.nz  = (p0_nvy >= 0) ? ZW'(ANG_PI) : -ZW'(ANG_PI);
      init.nvx = -p0_nvx;
      init.nvy = -p0_nvy;
      init.px  = -CW'(p0_dx);
      init.py  = -CW'(p0_dy);
    end else begin
      init.nz  = '0;
      init.nvx = p0_nvx;
      init.nvy = p0_nvy;
      init.px  = CW'(p0_dx);
      init.py  = CW'(p0_dy);
    end
    if (p0_gvx < 0) begin
      init.gz  = (p0_gvy >= 0) ? ZW'(ANG_PI) : -ZW'(ANG_PI);
      init.gvx = -p0_gvx;
      init.gvy = -p0_gvy;
    end else begin
      init.gz  = '0;
      init.gvx = p0_gvx;
      init.gvy = p0_gvy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) lv[0] <= 1'b0;
    else if (en) lv[0] <= p0v;
  end

  always_ff @(posedge clk) begin
    if (en) lp[0] <= init;
  end

  // One root bit per stage; the first stages also run one CORDIC step
  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    localparam int B = SQRT_STAGES - 1 - k;
    stage_t     rot;
    stage_t     nx;
    logic [65:0] rhs;

    if (k < CORDIC_ITERATIONS) begin : g_rot
      always_comb begin
        rot = lp[k];
        if (lp[k].nvy > 0) begin
          rot.nvx = lp[k].nvx + (lp[k].nvy >>> k);
          rot.nvy = lp[k].nvy - (lp[k].nvx >>> k);
          rot.px  = lp[k].px + (lp[k].py >>> k);
          rot.py  = lp[k].py - (lp[k].px >>> k);
          rot.nz  = lp[k].nz + $signed(ZW'(ATAN_TABLE[k]));
        end else begin
          rot.nvx = lp[k].nvx - (lp[k].nvy >>> k);
          rot.nvy = lp[k].nvy + (lp[k].nvx >>> k);
          rot.px  = lp[k].px - (lp[k].py >>> k);
          rot.py  = lp[k].py + (lp[k].px >>> k);
          rot.nz  = lp[k].nz - $signed(ZW'(ATAN_TABLE[k]));
        end
        if (lp[k].gvy > 0) begin
          rot.gvx = lp[k].gvx + (lp[k].gvy >>> k);
          rot.gvy = lp[k].gvy - (lp[k].gvx >>> k);
          rot.gz  = lp[k].gz + $signed(ZW'(ATAN_TABLE[k]));
        end else begin
          rot.gvx = lp[k].gvx - (lp[k].gvy >>> k);
          rot.gvy = lp[k].gvy + (lp[k].gvx >>> k);
          rot.gz  = lp[k].gz - $signed(ZW'(ATAN_TABLE[k]));
        end
      end
    end else begin : g_hold
      assign rot = lp[k];
    end

    assign rhs = (66'(lp[k].root) << (B + 1)) | (66'd1 << (2 * B));

    always_comb begin
      nx = rot;
      if (lp[k].rem >= rhs) begin
        nx.rem  = lp[k].rem - rhs;
        nx.root = lp[k].root | (32'd1 << B);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) lv[k+1] <= 1'b0;
      else if (en) lv[k+1] <= lv[k];
    end

    always_ff @(posedge clk) begin
      if (en) lp[k+1] <= nx;
    end
  end

  // Stage Q1: gain compensation partial products, yaw difference wrap
  logic                    q1v;
  logic signed [CW-16+30:0] q1_phx, q1_phy;
  logic signed [47:0]      q1_plx, q1_ply;
  logic signed [EW-1:0]    q1_e;
  logic signed [EW-1:0]    e_raw;
  logic signed [31:0]      q1_dx, q1_dy;
  logic [31:0]             q1_dist;
  logic                    q1_ndeg;

  always_comb begin
    e_raw = (lp[SQRT_STAGES].gdeg ? '0 : EW'(lp[SQRT_STAGES].gz))
          - (lp[SQRT_STAGES].ndeg ? '0 : EW'(lp[SQRT_STAGES].nz));
  end

  always_ff @(posedge clk) begin
    if (rst) q1v <= 1'b0;
    else if (en) q1v <= lv[SQRT_STAGES];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q1_phx  <= $signed(lp[SQRT_STAGES].px[CW-1:16]) * CORDIC_K;
      q1_phy  <= $signed(lp[SQRT_STAGES].py[CW-1:16]) * CORDIC_K;
      q1_plx  <= $signed({1'b0, lp[SQRT_STAGES].px[15:0]}) * CORDIC_K;
      q1_ply  <= $signed({1'b0, lp[SQRT_STAGES].py[15:0]}) * CORDIC_K;
      if (e_raw > EW'(ANG_PI)) q1_e <= e_raw - EW'(ANG_TWO_PI);
      else if (e_raw < -EW'(ANG_PI)) q1_e <= e_raw + EW'(ANG_TWO_PI);
      else q1_e <= e_raw;
      q1_dx   <= lp[SQRT_STAGES].dx;
      q1_dy   <= lp[SQRT_STAGES].dy;
      q1_dist <= lp[SQRT_STAGES].root;
      q1_ndeg <= lp[SQRT_STAGES].ndeg;
    end
  end

  // Stage Q2: robot-frame error and Q3.13 yaw error
  logic                 q2v;
  logic signed [RW-1:0] q2_rx, q2_ry;
  logic signed [HW-1:0] q2_he;
  logic [31:0]          q2_dist;
  logic signed [MW-1:0] sum_x, sum_y;

  always_comb begin
    sum_x = (MW'(q1_phx) <<< 16) + MW'(q1_plx) + (MW'(1) <<< 29);
    sum_y = (MW'(q1_phy) <<< 16) + MW'(q1_ply) + (MW'(1) <<< 29);
  end

  always_ff @(posedge clk) begin
    if (rst) q2v <= 1'b0;
    else if (en) q2v <= q1v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q2_rx   <= q1_ndeg ? RW'(q1_dx) : RW'(sum_x >>> 30);
      q2_ry   <= q1_ndeg ? RW'(q1_dy) : RW'(sum_y >>> 30);
      q2_he   <= HW'((q1_e + (EW'(1) <<< (HE_SHIFT - 1))) >>> HE_SHIFT);
      q2_dist <= q1_dist;
    end
  end

  // Stage Q3: gain products, deadband and arrival tests
  logic                 q3v;
  logic signed [52:0]   q3_prx, q3_pry;
  logic signed [36:0]   q3_prh;
  logic                 q3_negx, q3_negy, q3_negh;
  logic                 q3_deadx, q3_deady, q3_deadh;
  logic                 q3_arr;
  logic [31:0]          q3_dist;
  logic [15:0]          q3_head;
  logic [19:0]          pdb;
  logic [14:0]          ydb;
  logic signed [RW-1:0] ax, ay;
  logic signed [HW-1:0] ah;

  always_comb begin
    pdb = ((cfg.position_tolerance >> 1) < POS_DEADBAND_MIN) ?
          POS_DEADBAND_MIN : (cfg.position_tolerance >> 1);
    ydb = ((cfg.heading_tolerance >> 1) < YAW_DEADBAND_MIN) ?
          YAW_DEADBAND_MIN : (cfg.heading_tolerance >> 1);
    ax  = (q2_rx < 0) ? -q2_rx : q2_rx;
    ay  = (q2_ry < 0) ? -q2_ry : q2_ry;
    ah  = (q2_he < 0) ? -q2_he : q2_he;
  end

  always_ff @(posedge clk) begin
    if (rst) q3v <= 1'b0;
    else if (en) q3v <= q2v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q3_prx   <= $signed({1'b0, cfg.linear_gain}) * q2_rx;
      q3_pry   <= $signed({1'b0, cfg.linear_gain}) * q2_ry;
      q3_prh   <= $signed({1'b0, cfg.turn_gain}) * q2_he;
      q3_negx  <= q2_rx < 0;
      q3_negy  <= q2_ry < 0;
      q3_negh  <= q2_he < 0;
      q3_deadx <= $unsigned(ax) <= RW'(pdb);
      q3_deady <= $unsigned(ay) <= RW'(pdb);
      q3_deadh <= $unsigned(ah) <= HW'(ydb);
      q3_arr   <= (q2_dist < 32'(cfg.position_tolerance)) &&
                  ($unsigned(ah) < HW'(cfg.heading_tolerance));
      q3_dist  <= q2_dist;
      q3_head  <= q2_he[15:0];
    end
  end

  // Output register: rounding, minimum magnitude, clamp, deadband
  logic signed [20:0] cmd_x, cmd_y, cmd_h;

  always_comb begin
    cmd_x = finish_cmd((PW'(q3_prx) + (PW'(1) <<< (LIN_SHIFT - 1))) >>> LIN_SHIFT,
                       q3_negx, q3_deadx, cfg.linear_min_command,
                       cfg.linear_max_command);
    cmd_y = finish_cmd((PW'(q3_pry) + (PW'(1) <<< (LIN_SHIFT - 1))) >>> LIN_SHIFT,
                       q3_negy, q3_deady, cfg.linear_min_command,
                       cfg.linear_max_command);
    cmd_h = finish_cmd((PW'(q3_prh) + (PW'(1) <<< (TURN_SHIFT - 1))) >>> TURN_SHIFT,
                       q3_negh, q3_deadh, cfg.turn_min_command,
                       cfg.turn_max_command);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= q3v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= {q3_head, q3_dist, q3_arr, cmd_h, cmd_y, cmd_x};
    end
  end

endmodule

FILE: hdl/omni_pose_fine_controller.sv
// Proportional pose controller for an omnidirectional base. Each transfer on
// the input stream carries a current and a goal pose; one result comes back
// per input, in order, with robot-frame x/y velocity, yaw rate, the distance
// to the goal, the wrapped yaw error and an arrival flag. The block takes one
// item per clock while the output is not stalled, and has no state between
// items. Items pass the front stage, the four-entry queue, two setup stages,
// 32 square-root stages (the first 16 also run the CORDIC steps for both
// yaws), and stages Q1 to Q3 of scaling and command shaping, ending in the
// output register. A stalled output holds the back pipeline; the queue and
// front stage keep taking items until full. The user writes gains and limits
// on the cfg port only while the block is idle; the block does not enforce it.
module omni_pose_fine_controller (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // now_pos_x, now_pos_y, now_quat_x/y/z/w, target_pos_x, target_pos_y,
  // target_quat_x/y/z/w
  input  logic [255:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // velocity_x, velocity_y, turn_rate, arrived, range_to_goal, heading_error
  output logic [111:0] m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import opfc_pkg::*;

  cfg_t   cfg;
  front_t f_item, q_item;
  logic   f_valid, f_ready, q_valid, q_ready;

  assign cfg_ready = 1'b1;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.position_tolerance <= 20'd3277;
      cfg.heading_tolerance  <= 15'd410;
      cfg.linear_gain        <= 16'd256;
      cfg.linear_min_command <= 20'd0;
      cfg.linear_max_command <= 20'd32768;
      cfg.turn_gain          <= 16'd256;
      cfg.turn_min_command   <= 20'd0;
      cfg.turn_max_command   <= 20'd65536;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_POSITION_TOLERANCE: cfg.position_tolerance <= cfg_data[19:0];
        REG_HEADING_TOLERANCE:  cfg.heading_tolerance  <= cfg_data[14:0];
        REG_LINEAR_GAIN:        cfg.linear_gain        <= cfg_data[15:0];
        REG_LINEAR_MIN_COMMAND: cfg.linear_min_command <= cfg_data[19:0];
        REG_LINEAR_MAX_COMMAND: cfg.linear_max_command <= cfg_data[19:0];
        REG_TURN_GAIN:          cfg.turn_gain          <= cfg_data[15:0];
        REG_TURN_MIN_COMMAND:   cfg.turn_min_command   <= cfg_data[19:0];
        REG_TURN_MAX_COMMAND:   cfg.turn_max_command   <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  opfc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_item  (f_item)
  );

  opfc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  opfc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_item   (q_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

FILE: hdl/opfc_checker.sv
`include "assert_macros.svh"

module opfc_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [111:0] m_axis_tdata,
  input logic         cfg_valid,
  input logic         cfg_ready
);

  // A stalled result holds its place and value
  `OPFC_ASSERT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // No result right after reset
  `OPFC_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_axis_tvalid, "result valid after reset")

  // Register writes never wait
  `OPFC_ASSERT(a_cfg_ready, clk, rst, cfg_valid |-> cfg_ready, "config write stalled")

  // The symmetric clamp never yields the most negative code
  `OPFC_ASSERT(a_turn_range, clk, rst, m_axis_tvalid |-> m_axis_tdata[62:42] != 21'h100000, "turn rate outside clamp")

endmodule

bind omni_pose_fine_controller opfc_checker u_opfc_checker (.*);
